// ===== src/state_notification_table_defines.svh =====
// Assertion helpers for the state notification table.
`ifndef STATE_NOTIFICATION_TABLE_DEFINES_SVH
`define STATE_NOTIFICATION_TABLE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SNT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define SNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/snt_pkg.sv =====
`timescale 1ns / 1ps

package snt_pkg;

    localparam int SNT_SLOTS_DEFAULT = 8;

    localparam int STATE_W  = 8;
    localparam int THREAD_W = 8;
    localparam int SIGNAL_W = 31;
    localparam int ENTRY_W  = STATE_W + THREAD_W + SIGNAL_W;

    typedef enum logic [1:0] {
        KIND_SUBSCRIBE   = 2'd0,
        KIND_UNSUBSCRIBE = 2'd1,
        KIND_UPDATE      = 2'd2,
        KIND_FLUSH       = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ACT_SET    = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_STATUS = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RD,
        ST_CMP,
        ST_STATUS
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic next_idx;
        logic rd_en;
        logic sub_write;
        logic set_refused;
        logic flush;
        logic free_slot;
        logic emit_clear;
        logic emit_notify;
        logic emit_status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_kind kind;
        logic  cur_valid;
        logic  last_idx;
        logic  match;
        logic  out_free;
    } t_dp_stat;

endpackage

// ===== src/snt_ram.sv =====
`timescale 1ns / 1ps

module snt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/snt_dp.sv =====
`timescale 1ns / 1ps

module snt_dp
    import snt_pkg::*;
#(
    parameter int SLOTS = SNT_SLOTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_kind,
    input  logic [STATE_W-1:0]  i_state_code,
    input  logic [THREAD_W-1:0] i_thread_num,
    input  logic [SIGNAL_W-1:0] i_signal_mask,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_action,
    output logic [THREAD_W-1:0] o_target_thread,
    output logic [SIGNAL_W-1:0] o_target_signal,
    output logic                o_refused,
    output logic                o_is_empty,
    output logic                o_is_full,
    output logic                o_last
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // command word
    t_kind               r_kind, n_kind;
    logic [STATE_W-1:0]  r_state_code, n_state_code;
    logic [THREAD_W-1:0] r_thread, n_thread;
    logic [SIGNAL_W-1:0] r_signal, n_signal;

    // table control
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_refused, n_refused;

    // result register
    logic                r_out_valid, n_out_valid;
    t_action             r_action, n_action;
    logic [THREAD_W-1:0] r_tgt_thread, n_tgt_thread;
    logic [SIGNAL_W-1:0] r_tgt_signal, n_tgt_signal;
    logic                r_o_refused, n_o_refused;
    logic                r_o_empty, n_o_empty;
    logic                r_o_full, n_o_full;
    logic                r_o_last, n_o_last;

    logic [ENTRY_W-1:0]  w_rdata;
    logic [STATE_W-1:0]  w_rd_state;
    logic [THREAD_W-1:0] w_rd_thread;
    logic [SIGNAL_W-1:0] w_rd_signal;
    logic                w_out_free;
    logic                w_match;

    snt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sub_write),
        .i_waddr (r_idx),
        .i_wdata ({r_state_code, r_thread, r_signal}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign {w_rd_state, w_rd_thread, w_rd_signal} = w_rdata;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_match = 1'b0;
        unique case (r_kind)
            KIND_UNSUBSCRIBE: w_match = r_valid[r_idx] && (w_rd_thread == r_thread)
                                        && (w_rd_signal == r_signal);
            KIND_UPDATE:      w_match = r_valid[r_idx] && (w_rd_state == r_state_code);
            KIND_SUBSCRIBE,
            KIND_FLUSH:       w_match = 1'b0;
            default:          w_match = 1'b0;
        endcase
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.cur_valid = r_valid[r_idx];
    assign o_stat.last_idx  = (r_idx == IDX_W'(SLOTS - 1));
    assign o_stat.match     = w_match;
    assign o_stat.out_free  = w_out_free;

    always_comb begin
        n_kind       = r_kind;
        n_state_code = r_state_code;
        n_thread     = r_thread;
        n_signal     = r_signal;
        n_idx        = r_idx;
        n_valid      = r_valid;
        n_count      = r_count;
        n_refused    = r_refused;

        if (i_cmd.accept) begin
            n_kind       = t_kind'(i_kind);
            n_state_code = i_state_code;
            n_thread     = i_thread_num;
            n_signal     = i_signal_mask;
            n_idx        = '0;
            n_refused    = 1'b0;
        end
        if (i_cmd.next_idx) begin
            n_idx = r_idx + IDX_W'(1);
        end
        if (i_cmd.set_refused) begin
            n_refused = 1'b1;
        end
        if (i_cmd.sub_write) begin
            n_valid[r_idx] = 1'b1;
            n_count        = r_count + CNT_W'(1);
        end
        if (i_cmd.free_slot) begin
            n_valid[r_idx] = 1'b0;
            n_count        = r_count - CNT_W'(1);
        end
        if (i_cmd.flush) begin
            n_valid = '0;
            n_count = '0;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid && !i_out_ready;
        n_action     = r_action;
        n_tgt_thread = r_tgt_thread;
        n_tgt_signal = r_tgt_signal;
        n_o_refused  = r_o_refused;
        n_o_empty    = r_o_empty;
        n_o_full     = r_o_full;
        n_o_last     = r_o_last;

        priority if (i_cmd.emit_clear) begin
            n_out_valid  = 1'b1;
            n_action     = ACT_CLEAR;
            n_tgt_thread = r_thread;
            n_tgt_signal = r_signal;
            n_o_refused  = 1'b0;
            n_o_empty    = 1'b0;
            n_o_full     = 1'b0;
            n_o_last     = 1'b0;
        end else if (i_cmd.emit_notify) begin
            n_out_valid  = 1'b1;
            n_action     = ACT_SET;
            n_tgt_thread = w_rd_thread;
            n_tgt_signal = w_rd_signal;
            n_o_refused  = 1'b0;
            n_o_empty    = 1'b0;
            n_o_full     = 1'b0;
            n_o_last     = 1'b0;
        end else if (i_cmd.emit_status) begin
            n_out_valid  = 1'b1;
            n_action     = ACT_STATUS;
            n_tgt_thread = '0;
            n_tgt_signal = '0;
            n_o_refused  = r_refused;
            n_o_empty    = (r_count == '0);
            n_o_full     = (r_count == CNT_W'(SLOTS));
            n_o_last     = 1'b1;
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_valid     <= '0;
            r_count     <= '0;
            r_refused   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_refused   <= n_refused;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_state_code <= n_state_code;
        r_thread     <= n_thread;
        r_signal     <= n_signal;
        r_action     <= n_action;
        r_tgt_thread <= n_tgt_thread;
        r_tgt_signal <= n_tgt_signal;
        r_o_refused  <= n_o_refused;
        r_o_empty    <= n_o_empty;
        r_o_full     <= n_o_full;
        r_o_last     <= n_o_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_action        = r_action;
    assign o_target_thread = r_tgt_thread;
    assign o_target_signal = r_tgt_signal;
    assign o_refused       = r_o_refused;
    assign o_is_empty      = r_o_empty;
    assign o_is_full       = r_o_full;
    assign o_last          = r_o_last;

endmodule

// ===== src/snt_ctrl.sv =====
`timescale 1ns / 1ps

module snt_ctrl
    import snt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_START;
                end
            end

            ST_START: begin
                unique case (i_stat.kind)
                    KIND_UNSUBSCRIBE: begin
                        // clear-flags word goes out ahead of the scan
                        if (i_stat.out_free) begin
                            o_cmd.emit_clear = 1'b1;
                            n_state          = ST_RD;
                        end
                    end
                    KIND_FLUSH: begin
                        o_cmd.flush = 1'b1;
                        n_state     = ST_STATUS;
                    end
                    KIND_SUBSCRIBE,
                    KIND_UPDATE: n_state = ST_RD;
                    default:     n_state = ST_RD;
                endcase
            end

            ST_RD: begin
                if (i_stat.kind == KIND_SUBSCRIBE) begin
                    if (!i_stat.cur_valid) begin
                        o_cmd.sub_write = 1'b1;
                        n_state         = ST_STATUS;
                    end else if (i_stat.last_idx) begin
                        o_cmd.set_refused = 1'b1;
                        n_state           = ST_STATUS;
                    end else begin
                        o_cmd.next_idx = 1'b1;
                    end
                end else if (i_stat.cur_valid) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_CMP;
                end else if (i_stat.last_idx) begin
                    n_state = ST_STATUS;
                end else begin
                    o_cmd.next_idx = 1'b1;
                end
            end

            ST_CMP: begin
                // update frees a matching slot only together with placing its notify word
                if (!(i_stat.match && i_stat.kind == KIND_UPDATE && !i_stat.out_free)) begin
                    if (i_stat.match) begin
                        o_cmd.free_slot   = 1'b1;
                        o_cmd.emit_notify = (i_stat.kind == KIND_UPDATE);
                    end
                    if (i_stat.last_idx) begin
                        n_state = ST_STATUS;
                    end else begin
                        o_cmd.next_idx = 1'b1;
                        n_state        = ST_RD;
                    end
                end
            end

            ST_STATUS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state           = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== src/state_notification_table.sv =====
`timescale 1ns / 1ps
// State notification table: SLOTS subscriptions of (state, thread, signal mask).
// Input channel (i_in_valid / o_in_ready) takes one command word: subscribe,
// unsubscribe, update state or flush. Output channel (o_out_valid / i_out_ready)
// returns result words: clear-flags (unsubscribe), one set-flags per matching
// slot (update, slot order), then always one status word with last = 1 that
// carries refused, is_empty and is_full as of the end of the command.
// One command at a time: ready is high only when the table is idle.
// The slot scan runs through the entry RAM (one read port, registered read):
// subscribe stops at the first free slot; unsubscribe and update pass a read
// state and then a compare state for each valid slot.
// A one-word output register sits between the scan and the receiver; a
// stalled receiver holds the scan at the next word to emit, nothing is lost.
// Reset (synchronous, active low) clears all valid bits and the slot count;
// the entry RAM needs no clearing pass since unwritten entries are never read.

`include "state_notification_table_defines.svh"

module state_notification_table
    import snt_pkg::*;
#(
    parameter int SLOTS = SNT_SLOTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_kind,
    input  logic [STATE_W-1:0]  i_state_code,
    input  logic [THREAD_W-1:0] i_thread_num,
    input  logic [SIGNAL_W-1:0] i_signal_mask,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_action,
    output logic [THREAD_W-1:0] o_target_thread,
    output logic [SIGNAL_W-1:0] o_target_signal,
    output logic                o_refused,
    output logic                o_is_empty,
    output logic                o_is_full,
    output logic                o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: walks the slots, decides when to emit and when to free
    snt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // valid bits, slot count, entry RAM, result register
    snt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_kind          (i_kind),
        .i_state_code    (i_state_code),
        .i_thread_num    (i_thread_num),
        .i_signal_mask   (i_signal_mask),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_action        (o_action),
        .o_target_thread (o_target_thread),
        .o_target_signal (o_target_signal),
        .o_refused       (o_refused),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full),
        .o_last          (o_last)
    );

    // a new command never enters on the cycle after one was taken
    `SNT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // the result register is loaded only when it is free
    `SNT_ASSERT_NOW(a_emit_when_free, i_clk, i_rst_n,
        w_cmd.emit_clear || w_cmd.emit_notify || w_cmd.emit_status, w_stat.out_free)

    // the closing word of a command is always a status word
    `SNT_ASSERT_NOW(a_last_is_status, i_clk, i_rst_n, o_out_valid && o_last,
        o_action == ACT_STATUS)

    // a table cannot be full and empty at once
    `SNT_ASSERT_NOW(a_full_xor_empty, i_clk, i_rst_n, o_out_valid, !(o_is_full && o_is_empty))

endmodule

// ===== tb/tb_state_notification_table.sv =====
`timescale 1ns / 1ps

module tb_state_notification_table;
    import snt_pkg::*;

    localparam int SLOTS        = SNT_SLOTS_DEFAULT;
    // Settle margin: covers the scan of the worst command plus the output register.
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_PRINTED   = 40;

    // One result word as the receiver sees it.
    typedef struct packed {
        t_action               action;
        logic [THREAD_W-1:0]   thread;
        logic [SIGNAL_W-1:0]   signal;
        logic                  refused;
        logic                  empty;
        logic                  full;
        logic                  last;
    } t_snt_word;

    // Clock and reset; every input has a known value from time zero.
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic [1:0]          i_kind        = '0;
    logic [STATE_W-1:0]  i_state_code  = '0;
    logic [THREAD_W-1:0] i_thread_num  = '0;
    logic [SIGNAL_W-1:0] i_signal_mask = '0;
    logic                i_out_ready   = 1'b0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [1:0]          o_action;
    logic [THREAD_W-1:0] o_target_thread;
    logic [SIGNAL_W-1:0] o_target_signal;
    logic                o_refused;
    logic                o_is_empty;
    logic                o_is_full;
    logic                o_last;

    // Shadow copy of the subscription table.
    logic                tbl_valid  [SLOTS];
    logic [STATE_W-1:0]  tbl_state  [SLOTS];
    logic [THREAD_W-1:0] tbl_thread [SLOTS];
    logic [SIGNAL_W-1:0] tbl_signal [SLOTS];

    // Result words predicted but not yet seen, oldest first.
    t_snt_word pending_words[$];

    int  mismatch_count = 0;
    int  words_seen     = 0;

    // Sender pacing: bursts of back-to-back words separated by random gaps.
    bit  tx_gaps_on = 1'b0;
    int  burst_left = 0;

    // Receiver pacing: 0 always ready, 1 random, 2 fixed pattern, 3 random runs.
    int  rx_mode  = 0;
    bit  hold_req = 1'b0;

    state_notification_table #(
        .SLOTS(SLOTS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_state_code    (i_state_code),
        .i_thread_num    (i_thread_num),
        .i_signal_mask   (i_signal_mask),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_action        (o_action),
        .o_target_thread (o_target_thread),
        .o_target_signal (o_target_signal),
        .o_refused       (o_refused),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full),
        .o_last          (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction: apply one accepted command to the shadow table and queue
    // every result word it causes, status word last.
    // ------------------------------------------------------------------
    function automatic void predict_command(t_kind kind, logic [STATE_W-1:0] st,
                                            logic [THREAD_W-1:0] thr,
                                            logic [SIGNAL_W-1:0] sig);
        t_snt_word w;
        logic      refused;
        int        free_idx;
        int        used;
        refused  = 1'b0;
        free_idx = -1;
        used     = 0;
        case (kind)
            KIND_SUBSCRIBE: begin
                // lowest free slot wins; duplicates are fine
                for (int i = 0; i < SLOTS; i++) begin
                    if (!tbl_valid[i] && free_idx < 0) free_idx = i;
                end
                if (free_idx < 0) begin
                    refused = 1'b1;
                end else begin
                    tbl_valid[free_idx]  = 1'b1;
                    tbl_state[free_idx]  = st;
                    tbl_thread[free_idx] = thr;
                    tbl_signal[free_idx] = sig;
                end
            end
            KIND_UNSUBSCRIBE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_thread[i] == thr && tbl_signal[i] == sig)
                        tbl_valid[i] = 1'b0;
                end
                // clear word goes out even when nothing matched
                w = '{ACT_CLEAR, thr, sig, 1'b0, 1'b0, 1'b0, 1'b0};
                pending_words.push_back(w);
            end
            KIND_UPDATE: begin
                // one set word per matching slot, in slot order, then freed
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_state[i] == st) begin
                        w = '{ACT_SET, tbl_thread[i], tbl_signal[i],
                              1'b0, 1'b0, 1'b0, 1'b0};
                        pending_words.push_back(w);
                        tbl_valid[i] = 1'b0;
                    end
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
            end
        endcase
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i]) used++;
        end
        w = '{ACT_STATUS, '0, '0, refused, used == 0, used == SLOTS, 1'b1};
        pending_words.push_back(w);
    endfunction

    task automatic report_error(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every accepted output word against the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_snt_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                report_error($sformatf("word %0d arrived with nothing expected", words_seen));
            end else begin
                want = pending_words.pop_front();
                if (o_action != want.action)
                    report_error($sformatf("word %0d action %0d, want %0d",
                                           words_seen, o_action, want.action));
                if (o_target_thread != want.thread)
                    report_error($sformatf("word %0d thread %0h, want %0h",
                                           words_seen, o_target_thread, want.thread));
                if (o_target_signal != want.signal)
                    report_error($sformatf("word %0d signal %0h, want %0h",
                                           words_seen, o_target_signal, want.signal));
                if (o_refused != want.refused)
                    report_error($sformatf("word %0d refused %0b, want %0b",
                                           words_seen, o_refused, want.refused));
                if (o_is_empty != want.empty)
                    report_error($sformatf("word %0d is_empty %0b, want %0b",
                                           words_seen, o_is_empty, want.empty));
                if (o_is_full != want.full)
                    report_error($sformatf("word %0d is_full %0b, want %0b",
                                           words_seen, o_is_full, want.full));
                if (o_last != want.last)
                    report_error($sformatf("word %0d last %0b, want %0b",
                                           words_seen, o_last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows rx_mode, except for a long hold-off that a
    // test may request; the hold is counted here in cycles.
    // ------------------------------------------------------------------
    initial begin : rx_side
        int   hold_left;
        int   tick;
        int   run_left;
        logic run_level;
        hold_left = 0;
        tick      = 0;
        run_left  = 0;
        run_level = 1'b1;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= ((tick % 7) != 2) && ((tick % 7) != 5);
                    default: begin
                        if (run_left == 0) begin
                            run_level = ~run_level;
                            run_left  = $urandom_range(1, 12);
                        end
                        run_left--;
                        i_out_ready <= run_level;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: offer one command word, hold it until taken, then predict.
    // Valid is left high after acceptance unless a gap follows; the next
    // send or settle_table takes it from there.
    // ------------------------------------------------------------------
    task automatic send_word(t_kind kind, logic [STATE_W-1:0] st,
                             logic [THREAD_W-1:0] thr, logic [SIGNAL_W-1:0] sig);
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_state_code  <= st;
        i_thread_num  <= thr;
        i_signal_mask <= sig;
        do @(posedge i_clk); while (!o_in_ready);
        predict_command(kind, st, thr, sig);
        if (tx_gaps_on) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop offering, wait for every predicted word, then let the scan finish.
    task automatic settle_table();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random valid slot of the shadow table, or -1 when empty.
    function automatic int pick_live_slot();
        int start;
        start = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[(start + i) % SLOTS]) return (start + i) % SLOTS;
        end
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Flush, update and unsubscribe on a freshly reset table.
    task automatic test_empty_table();
        rx_mode    = 0;
        tx_gaps_on = 1'b0;
        send_word(KIND_FLUSH, 8'h00, 8'h00, 31'h0);
        send_word(KIND_UPDATE, 8'hFF, 8'hFF, 31'h7FFF_FFFF);
        send_word(KIND_UNSUBSCRIBE, 8'h00, 8'h00, 31'h0);   // no match, clear still sent
        settle_table();
    endtask

    // Fill every slot with field extremes and a duplicate, then get refused.
    task automatic test_fill_and_refuse();
        rx_mode    = 1;
        tx_gaps_on = 1'b1;
        send_word(KIND_SUBSCRIBE, 8'h00, 8'h00, 31'h0);         // thread zero
        send_word(KIND_SUBSCRIBE, 8'hFF, 8'hFF, 31'h7FFF_FFFF);
        send_word(KIND_SUBSCRIBE, 8'h55, 8'hAA, 31'h2AAA_AAAA);
        send_word(KIND_SUBSCRIBE, 8'hAA, 8'h55, 31'h5555_5555);
        send_word(KIND_SUBSCRIBE, 8'h07, 8'h03, 31'h1);
        send_word(KIND_SUBSCRIBE, 8'h07, 8'h03, 31'h1);         // duplicate
        send_word(KIND_SUBSCRIBE, 8'hFF, 8'h00, 31'h4000_0000);
        send_word(KIND_SUBSCRIBE, 8'h80, 8'h80, 31'h7FFF_FFFF); // now full
        send_word(KIND_SUBSCRIBE, 8'h01, 8'h01, 31'h1);         // refused
        settle_table();
    endtask

    // Matching, freeing and slot reuse on the table left by the fill test.
    task automatic test_match_and_free();
        rx_mode    = 2;
        tx_gaps_on = 1'b1;
        send_word(KIND_UNSUBSCRIBE, 8'h00, 8'h03, 31'h1);   // frees both duplicates
        send_word(KIND_UPDATE, 8'hFF, 8'h00, 31'h0);        // two notifies, slot order
        send_word(KIND_SUBSCRIBE, 8'hFF, 8'h09, 31'h9);     // reuses lowest free slot
        send_word(KIND_UNSUBSCRIBE, 8'h00, 8'h09, 31'h8);   // signal differs: no match
        send_word(KIND_UPDATE, 8'h11, 8'h00, 31'h0);        // no match: status only
        send_word(KIND_UPDATE, 8'h00, 8'h00, 31'h0);
        send_word(KIND_FLUSH, 8'hFF, 8'hFF, 31'h7FFF_FFFF);
        send_word(KIND_UPDATE, 8'hFF, 8'h00, 31'h0);        // after flush: nothing left
        settle_table();
    endtask

    // Long receiver hold-off while commands keep coming: the output register
    // fills, the scan stops and the input channel must back up.
    task automatic test_output_stall();
        rx_mode    = 0;
        tx_gaps_on = 1'b0;
        hold_req   = 1'b1;
        send_word(KIND_SUBSCRIBE, 8'h21, 8'h10, 31'h100);
        send_word(KIND_SUBSCRIBE, 8'h21, 8'h11, 31'h200);
        send_word(KIND_SUBSCRIBE, 8'h22, 8'h12, 31'h300);
        send_word(KIND_UPDATE, 8'h21, 8'h00, 31'h0);
        send_word(KIND_UNSUBSCRIBE, 8'h00, 8'h12, 31'h300);
        send_word(KIND_SUBSCRIBE, 8'h23, 8'h13, 31'h400);
        settle_table();
    endtask

    // Mostly well-formed traffic: states from a small pool so updates hit,
    // unsubscribes aimed at live entries, plus full-range noise.
    task automatic test_random_traffic(int n_cmds);
        int                  pick;
        int                  idx;
        t_kind               kind;
        logic [STATE_W-1:0]  st;
        logic [THREAD_W-1:0] thr;
        logic [SIGNAL_W-1:0] sig;
        for (int n = 0; n < n_cmds; n++) begin
            if (n % 30 == 0) begin
                rx_mode    = $urandom_range(0, 3);
                tx_gaps_on = ($urandom_range(0, 3) != 0);
            end
            st  = STATE_W'(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 3));
            thr = THREAD_W'(($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 3));
            sig = SIGNAL_W'(($urandom_range(0, 1) == 0) ? $urandom()
                                                          : (32'h1 << $urandom_range(0, 30)));
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                kind = KIND_SUBSCRIBE;
            end else if (pick < 65) begin
                kind = KIND_UNSUBSCRIBE;
                idx  = pick_live_slot();
                if (idx >= 0 && $urandom_range(0, 3) != 0) begin
                    thr = tbl_thread[idx];
                    sig = tbl_signal[idx];
                end
            end else if (pick < 95) begin
                kind = KIND_UPDATE;
                idx  = pick_live_slot();
                if (idx >= 0 && $urandom_range(0, 3) != 0) st = tbl_state[idx];
            end else begin
                kind = KIND_FLUSH;
            end
            send_word(kind, st, thr, sig);
        end
        settle_table();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_fill_and_refuse();
        test_match_and_free();
        test_output_stall();
        test_random_traffic(104);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog, well above the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
